@@ rtl/eco_pkg.sv @@
package eco_pkg;

  localparam int MAX_EDGES = 64;
  localparam int IDX_W     = $clog2(MAX_EDGES);
  localparam int CNT_W     = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W    = 20;
  localparam int VTX_W     = 24;
  localparam int STEP_W    = 10;

  localparam logic [STEP_W-1:0] RESET_STEPS = STEP_W'(100);

  // search token that travels down the cell row, one cell per cycle
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [VTX_W-1:0]  vtx;
    logic [EDGE_W-1:0] cur_id;
  } token_t;

  typedef struct packed {
    logic wr;   // load this cell with the incoming edge
    logic clr;  // start of walk: reset the visited mark
  } cell_ctrl_t;

endpackage

@@ rtl/eco_ram.sv @@
module eco_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/eco_cell.sv @@
module eco_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  eco_pkg::cell_ctrl_t        ctrl_i,
  input  logic                       init_visited_i,
  input  logic                       occupied_i,
  input  logic [eco_pkg::EDGE_W-1:0] edge_id_i,
  input  logic [eco_pkg::VTX_W-1:0]  vertex_a_i,
  input  logic [eco_pkg::VTX_W-1:0]  vertex_b_i,
  input  eco_pkg::token_t            tok_i,
  output eco_pkg::token_t            tok_o
);
  import eco_pkg::*;

  logic [EDGE_W-1:0] id_q;
  logic [VTX_W-1:0]  va_q, vb_q;
  logic              visited_q, visited_d;
  token_t            tok_q, tok_d;
  logic              a_hit, b_hit, hit;

  assign a_hit = (va_q == tok_i.vtx);
  assign b_hit = (vb_q == tok_i.vtx);
  assign hit   = tok_i.valid && !tok_i.found && occupied_i && !visited_q &&
                 (id_q != tok_i.cur_id) && (a_hit || b_hit);

  always_comb begin
    tok_d     = tok_i;
    visited_d = visited_q;
    if (ctrl_i.clr) begin
      visited_d = init_visited_i;
    end else if (hit) begin
      visited_d = 1'b1;
    end
    if (hit) begin
      tok_d.found  = 1'b1;
      tok_d.vtx    = a_hit ? vb_q : va_q;
      tok_d.cur_id = id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= 1'b0;
      tok_q     <= '0;
    end else begin
      visited_q <= visited_d;
      tok_q     <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      id_q <= edge_id_i;
      va_q <= vertex_a_i;
      vb_q <= vertex_b_i;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ rtl/edge_chain_ordering_core.sv @@
// Loading: an edge is taken whenever start is high while idle; the next edge may follow in the next cycle.
// Walk: each step sends a search token down the 64-cell row;
// a direction ends with one failed search, or without a search once max_steps is reached.
// Output: nf + nb + 1 results, one per cycle, once the walk ends;
// busy stays high from the last edge through the walk and the emit of the results. The receiver cannot stall.
// Reset: asynchronous, active low; clears the store count and overflow, max_steps to 100.
module edge_chain_ordering_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [eco_pkg::EDGE_W-1:0]  edge_id_i,
  input  logic [eco_pkg::VTX_W-1:0]   vertex_a_i,
  input  logic [eco_pkg::VTX_W-1:0]   vertex_b_i,
  input  logic                        last_edge_i,
  input  logic                        cfg_we_i,
  input  logic [eco_pkg::STEP_W-1:0]  cfg_wdata_i,
  output logic                        result_valid_o,
  output logic [eco_pkg::EDGE_W-1:0]  loop_edge_id_o,
  output logic                        end_of_chain_o,
  output logic                        overflowed_o
);
  import eco_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    SEL_FRONT = 3'b001,
    SEL_MID   = 3'b010,
    SEL_BACK  = 3'b100
  } sel_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] max_steps_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [EDGE_W-1:0] id0_q, id0_d;
  logic [VTX_W-1:0]  va0_q, va0_d, vb0_q, vb0_d;
  logic [VTX_W-1:0]  vtx_q, vtx_d;
  logic [EDGE_W-1:0] cur_q, cur_d;
  logic              dir_q, dir_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [IDX_W-1:0]  nf_q, nf_d, nb_q, nb_d;
  logic [CNT_W-1:0]  k_q, k_d;

  logic              out_valid_q, out_valid_d;
  sel_e              out_sel_q, out_sel_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;
  logic [EDGE_W-1:0] out_mid_q, out_mid_d;

  logic              accept;
  logic              clr_visited;
  token_t            tok [MAX_EDGES+1];
  token_t            tok_end;
  logic              front_we, back_we;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  front_addr, back_addr;
  logic [EDGE_W-1:0] front_rdata, back_rdata;
  logic              in_front, is_last;

  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign tok_end = tok[MAX_EDGES];

  // ---------------- cell row ----------------
  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
    cell_ctrl_t cctrl;
    assign cctrl.wr  = accept && (count_q == CNT_W'(i));
    assign cctrl.clr = clr_visited;

    eco_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (cctrl),
      .init_visited_i (i == 0),
      .occupied_i     (CNT_W'(i) < count_q),
      .edge_id_i      (edge_id_i),
      .vertex_a_i     (vertex_a_i),
      .vertex_b_i     (vertex_b_i),
      .tok_i          (tok[i]),
      .tok_o          (tok[i+1])
    );
  end

  // token injection at the head of the row
  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = (state_q == ST_LAUNCH) && (step_q < max_steps_q);
    tok[0].vtx    = vtx_q;
    tok[0].cur_id = cur_q;
  end

  // ---------------- walk lists ----------------
  assign front_we = (state_q == ST_WAIT) && tok_end.valid && tok_end.found && !dir_q;
  assign back_we  = (state_q == ST_WAIT) && tok_end.valid && tok_end.found && dir_q;

  assign in_front   = (k_q < {1'b0, nf_q});
  assign is_last    = (k_q == ({1'b0, nf_q} + {1'b0, nb_q}));
  assign front_addr = nf_q - IDX_W'(1) - k_q[IDX_W-1:0];
  assign back_addr  = k_q[IDX_W-1:0] - nf_q - IDX_W'(1);
  assign raddr      = in_front ? front_addr : back_addr;

  eco_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (front_we),
    .waddr_i (nf_q),
    .wdata_i (tok_end.cur_id),
    .raddr_i (raddr),
    .rdata_o (front_rdata)
  );

  eco_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (back_we),
    .waddr_i (nb_q),
    .wdata_i (tok_end.cur_id),
    .raddr_i (raddr),
    .rdata_o (back_rdata)
  );

  // ---------------- control ----------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    id0_d       = id0_q;
    va0_d       = va0_q;
    vb0_d       = vb0_q;
    vtx_d       = vtx_q;
    cur_d       = cur_q;
    dir_d       = dir_q;
    step_d      = step_q;
    nf_d        = nf_q;
    nb_d        = nb_q;
    k_d         = k_q;
    clr_visited = 1'b0;
    out_valid_d = 1'b0;
    out_sel_d   = out_sel_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    out_mid_d   = out_mid_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (count_q == CNT_W'(MAX_EDGES)) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (count_q == '0) begin
            id0_d = edge_id_i;
            va0_d = vertex_a_i;
            vb0_d = vertex_b_i;
          end
          if (last_edge_i) begin
            clr_visited = 1'b1;
            dir_d       = 1'b0;
            step_d      = '0;
            nf_d        = '0;
            nb_d        = '0;
            vtx_d       = (count_q == '0) ? vertex_a_i : va0_q;
            cur_d       = (count_q == '0) ? edge_id_i : id0_q;
            state_d     = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH, ST_WAIT: begin
        if (state_q == ST_LAUNCH && step_q < max_steps_q) begin
          state_d = ST_WAIT;
        end else if (state_q == ST_WAIT && !tok_end.valid) begin
          state_d = ST_WAIT;
        end else if (state_q == ST_WAIT && tok_end.found) begin
          vtx_d   = tok_end.vtx;
          cur_d   = tok_end.cur_id;
          step_d  = step_q + STEP_W'(1);
          if (dir_q) begin
            nb_d = nb_q + IDX_W'(1);
          end else begin
            nf_d = nf_q + IDX_W'(1);
          end
          state_d = ST_LAUNCH;
        end else if (!dir_q) begin
          // front walk done, start the back walk from the other end vertex
          dir_d   = 1'b1;
          step_d  = '0;
          vtx_d   = vb0_q;
          cur_d   = id0_q;
          state_d = ST_LAUNCH;
        end else begin
          k_d     = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_d = 1'b1;
        out_last_d  = is_last;
        out_ovf_d   = ovf_q;
        out_mid_d   = id0_q;
        if (in_front) begin
          out_sel_d = SEL_FRONT;
        end else if (k_q == {1'b0, nf_q}) begin
          out_sel_d = SEL_MID;
        end else begin
          out_sel_d = SEL_BACK;
        end
        k_d = k_q + CNT_W'(1);
        if (is_last) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_steps_q <= RESET_STEPS;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      dir_q       <= 1'b0;
      step_q      <= '0;
      nf_q        <= '0;
      nb_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      dir_q       <= dir_d;
      step_q      <= step_d;
      nf_q        <= nf_d;
      nb_q        <= nb_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_steps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id0_q      <= id0_d;
    va0_q      <= va0_d;
    vb0_q      <= vb0_d;
    vtx_q      <= vtx_d;
    cur_q      <= cur_d;
    out_sel_q  <= out_sel_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
    out_mid_q  <= out_mid_d;
  end

  // ---------------- result port ----------------
  always_comb begin
    case (out_sel_q)
      SEL_FRONT: loop_edge_id_o = front_rdata;
      SEL_BACK:  loop_edge_id_o = back_rdata;
      default:   loop_edge_id_o = out_mid_q;
    endcase
  end

  assign result_valid_o = out_valid_q;
  assign end_of_chain_o = out_last_q;
  assign overflowed_o   = out_ovf_q;

  // ---------------- assertions ----------------
  a_tok_only_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.valid |-> state_q == ST_WAIT)
    else $error("search token left the row outside of a wait");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_EMIT))
    else $error("result strobe without an emit cycle");

  a_chain_end_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && end_of_chain_o |=> !result_valid_o)
    else $error("result after end of chain");

  a_full_sets_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && count_q == CNT_W'(MAX_EDGES) |=> ovf_q)
    else $error("dropped edge did not set overflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_EDGES))
    else $error("edge count beyond capacity");

endmodule

@@ test/edge_chain_ordering_core_test.sv @@
module edge_chain_ordering_core_test;
  import eco_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 350;
  localparam int SETTLE_CYCLES = 2 * (MAX_EDGES + 1);
  localparam int N_ROWS        = 24;
  localparam int EXP_DEPTH     = 256;

  typedef enum logic {ROW_EDGE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              lst;
    logic              typed;   // expected result written into the row
    logic [STEP_W-1:0] steps;   // ROW_CFG only
    logic [EDGE_W-1:0] eid;
    logic [VTX_W-1:0]  va;
    logic [VTX_W-1:0]  vb;
    logic [EDGE_W-1:0] x_id;
    logic              x_eoc;
    logic              x_ovf;
  } row_t;

  typedef struct packed {
    logic [EDGE_W-1:0] id;
    logic              eoc;
    logic              ovf;
  } chain_pos_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  logic [EDGE_W-1:0] edge_id_i   = '0;
  logic [VTX_W-1:0]  vertex_a_i  = '0;
  logic [VTX_W-1:0]  vertex_b_i  = '0;
  logic              last_edge_i = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [STEP_W-1:0] cfg_wdata_i = '0;
  logic              result_valid_o;
  logic [EDGE_W-1:0] loop_edge_id_o;
  logic              end_of_chain_o;
  logic              overflowed_o;

  edge_chain_ordering_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .edge_id_i      (edge_id_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .last_edge_i    (last_edge_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .loop_edge_id_o (loop_edge_id_o),
    .end_of_chain_o (end_of_chain_o),
    .overflowed_o   (overflowed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // chain predictor state
  logic [EDGE_W-1:0] st_id   [MAX_EDGES];
  logic [VTX_W-1:0]  st_va   [MAX_EDGES];
  logic [VTX_W-1:0]  st_vb   [MAX_EDGES];
  bit                st_seen [MAX_EDGES];
  int                front_idx [MAX_EDGES];
  int                back_idx  [MAX_EDGES];
  int                st_count  = 0;
  bit                st_ovf    = 1'b0;
  logic [STEP_W-1:0] cfg_steps = RESET_STEPS;

  // expected results, kept in a ring
  chain_pos_t expected_mem [EXP_DEPTH];
  int         exp_rd     = 0;
  int         exp_wr     = 0;
  int         exp_level  = 0;
  chain_pos_t want_pos;
  int         err_count  = 0;
  int         items_sent = 0;
  int         cycles     = 0;
  bit         no_gaps    = 1'b0;

  row_t dir_rows [N_ROWS] = '{
    // lone edges at both extremes
    '{ROW_EDGE, 1'b1, 1'b1, 10'd0, 20'h0, 24'h0, 24'h0, 20'h0, 1'b1, 1'b0},
    '{ROW_EDGE, 1'b1, 1'b1, 10'd0, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 1'b1, 1'b0},
    // open chain, first edge in the middle
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd5, 24'd10, 24'd11, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd6, 24'd11, 24'd12, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd7, 24'd9, 24'd10, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b1, 1'b0, 10'd0, 20'd8, 24'd12, 24'd13, 20'h0, 1'b0, 1'b0},
    // repeated ids: same id as current edge is skipped for one step only
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd3, 24'd1, 24'd2, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd3, 24'd2, 24'd4, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd9, 24'd2, 24'd5, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b1, 1'b0, 10'd0, 20'd4, 24'd5, 24'd1, 20'h0, 1'b0, 1'b0},
    // no steps: only the first edge comes out
    '{ROW_CFG,  1'b0, 1'b0, 10'd0, 20'h0, 24'h0, 24'h0, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd20, 24'd100, 24'd101, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd21, 24'd101, 24'd102, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b1, 1'b1, 10'd0, 20'd22, 24'd99, 24'd100, 20'd20, 1'b1, 1'b0},
    // one step each way
    '{ROW_CFG,  1'b0, 1'b0, 10'd1, 20'h0, 24'h0, 24'h0, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd30, 24'd0, 24'hFFFFFF, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd31, 24'hFFFFFF, 24'd5, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd32, 24'd6, 24'd0, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b1, 1'b0, 10'd0, 20'd33, 24'd5, 24'd6, 20'h0, 1'b0, 1'b0},
    // closed loop with a spur, widest step limit
    '{ROW_CFG,  1'b0, 1'b0, 10'd1023, 20'h0, 24'h0, 24'h0, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd40, 24'd1, 24'd2, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd41, 24'd2, 24'd3, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b0, 1'b0, 10'd0, 20'd42, 24'd3, 24'd1, 20'h0, 1'b0, 1'b0},
    '{ROW_EDGE, 1'b1, 1'b0, 10'd0, 20'd43, 24'd3, 24'd7, 20'h0, 1'b0, 1'b0}
  };

  task automatic report_mismatch(input string what);
    err_count++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic void exp_store(input chain_pos_t p);
    expected_mem[exp_wr] = p;
    exp_wr = (exp_wr + 1) % EXP_DEPTH;
    exp_level++;
  endfunction

  function automatic chain_pos_t exp_fetch();
    chain_pos_t p;
    p = expected_mem[exp_rd];
    exp_rd = (exp_rd + 1) % EXP_DEPTH;
    exp_level--;
    return p;
  endfunction

  // one walk direction; records the chosen store indices
  function automatic int walk_chain(input logic [VTX_W-1:0] start_v, input bit to_front);
    logic [VTX_W-1:0]  vtx;
    logic [EDGE_W-1:0] cur;
    int                n;
    bit                hit;
    vtx = start_v;
    cur = st_id[0];
    n = 0;
    for (int s = 0; s < int'(cfg_steps); s++) begin
      hit = 1'b0;
      for (int e = 0; e < st_count; e++) begin
        if (st_id[e] == cur || st_seen[e]) continue;
        if (st_va[e] == vtx) begin
          vtx = st_vb[e];
          hit = 1'b1;
        end else if (st_vb[e] == vtx) begin
          vtx = st_va[e];
          hit = 1'b1;
        end
        if (hit) begin
          cur = st_id[e];
          st_seen[e] = 1'b1;
          if (to_front) front_idx[n] = e;
          else back_idx[n] = e;
          n++;
          break;
        end
      end
      if (!hit) break;
    end
    return n;
  endfunction

  function automatic void predict_chain(input logic [EDGE_W-1:0] eid,
                                        input logic [VTX_W-1:0] va,
                                        input logic [VTX_W-1:0] vb,
                                        input logic lst, input bit keep);
    int nf, nb, total, idx;
    chain_pos_t pos;
    if (st_count < MAX_EDGES) begin
      st_id[st_count] = eid;
      st_va[st_count] = va;
      st_vb[st_count] = vb;
      st_count++;
    end else begin
      st_ovf = 1'b1;
    end
    if (!lst) return;
    for (int i = 0; i < MAX_EDGES; i++) st_seen[i] = 1'b0;
    st_seen[0] = 1'b1;
    nf = walk_chain(st_va[0], 1'b1);
    nb = walk_chain(st_vb[0], 1'b0);
    total = nf + 1 + nb;
    // front walk reversed, first edge, back walk
    for (int k = 0; k < total; k++) begin
      if (k < nf) idx = front_idx[nf - 1 - k];
      else if (k == nf) idx = 0;
      else idx = back_idx[k - nf - 1];
      pos.id  = st_id[idx];
      pos.eoc = (k == total - 1);
      pos.ovf = st_ovf;
      if (keep) exp_store(pos);
    end
    st_count = 0;
    st_ovf = 1'b0;
    for (int i = 0; i < MAX_EDGES; i++) st_seen[i] = 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_edge(input logic [EDGE_W-1:0] eid, input logic [VTX_W-1:0] va,
                           input logic [VTX_W-1:0] vb, input logic lst, input bit keep);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start       = 1'b1;
    edge_id_i   = eid;
    vertex_a_i  = va;
    vertex_b_i  = vb;
    last_edge_i = lst;
    do @(posedge clk_i); while (busy);
    predict_chain(eid, va, vb, lst, keep);
    items_sent++;
  endtask

  task automatic drain_results(input int settle);
    @(negedge clk_i);
    start = 1'b0;
    while (exp_level != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_steps(input logic [STEP_W-1:0] v);
    drain_results(8);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_steps   = v;
  endtask

  // results are strobed for one cycle; values read here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (exp_level == 0) begin
        report_mismatch($sformatf("unexpected result id %h", loop_edge_id_o));
      end else begin
        want_pos = exp_fetch();
        if (loop_edge_id_o !== want_pos.id)
          report_mismatch($sformatf("loop_edge_id %h, want %h", loop_edge_id_o, want_pos.id));
        if (end_of_chain_o !== want_pos.eoc)
          report_mismatch($sformatf("end_of_chain %b, want %b", end_of_chain_o, want_pos.eoc));
        if (overflowed_o !== want_pos.ovf)
          report_mismatch($sformatf("overflowed %b, want %b", overflowed_o, want_pos.ovf));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("edge_chain_ordering_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    logic [VTX_W-1:0]  vv    [MAX_EDGES + 1];
    logic [EDGE_W-1:0] ids   [MAX_EDGES];
    bit                flip  [MAX_EDGES];
    int                order [MAX_EDGES];
    int                n, i, j, tmp, r, rand_start, set_no;
    bit                closed, id_pool, small_pool, overflow_done;
    logic [VTX_W-1:0]  va, vb;
    logic [EDGE_W-1:0] eid;
    chain_pos_t        typed_pos;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int k = 0; k < N_ROWS; k++) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        write_steps(dir_rows[k].steps);
      end else begin
        send_edge(dir_rows[k].eid, dir_rows[k].va, dir_rows[k].vb, dir_rows[k].lst,
                  !dir_rows[k].typed);
        if (dir_rows[k].typed) begin
          typed_pos.id  = dir_rows[k].x_id;
          typed_pos.eoc = dir_rows[k].x_eoc;
          typed_pos.ovf = dir_rows[k].x_ovf;
          exp_store(typed_pos);
        end
      end
    end

    rand_start = items_sent;
    set_no = 0;
    overflow_done = 1'b0;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        r = $urandom_range(0, 7);
        case (r)
          0: write_steps(10'd0);
          1: write_steps(10'd1);
          2: write_steps(10'd1023);
          3: write_steps(RESET_STEPS);
          default: write_steps(STEP_W'($urandom_range(1, 1023)));
        endcase
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 3 || (set_no == 40 && !overflow_done)) begin
        // store overflow: extra edges dropped, the last one among them
        overflow_done = 1'b1;
        n = MAX_EDGES + $urandom_range(1, 3);
        for (int p = 0; p < n; p++)
          send_edge(EDGE_W'($urandom), VTX_W'($urandom_range(0, 15)),
                    VTX_W'($urandom_range(0, 15)), p == n - 1, 1'b1);
      end else if (r < 70) begin
        // well-formed path or loop, loaded in shuffled order
        r = $urandom_range(0, 99);
        if (r < 80) n = $urandom_range(1, 10);
        else if (r < 95) n = $urandom_range(11, 30);
        else n = $urandom_range(31, MAX_EDGES);
        closed  = (n >= 3) && ($urandom_range(0, 3) == 0);
        id_pool = ($urandom_range(0, 4) == 0);
        for (i = 0; i <= n; i++) vv[i] = VTX_W'($urandom);
        if (closed) vv[n] = vv[0];
        for (i = 0; i < n; i++) begin
          ids[i]   = id_pool ? EDGE_W'($urandom_range(0, 3)) : EDGE_W'($urandom);
          flip[i]  = $urandom_range(0, 1);
          order[i] = i;
        end
        for (i = n - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int p = 0; p < n; p++) begin
          i = order[p];
          va = flip[i] ? vv[i + 1] : vv[i];
          vb = flip[i] ? vv[i] : vv[i + 1];
          send_edge(ids[i], va, vb, p == n - 1, 1'b1);
        end
      end else begin
        // loose edges; a small vertex pool makes branches and repeats
        n = $urandom_range(1, 8);
        small_pool = $urandom_range(0, 1);
        for (int p = 0; p < n; p++) begin
          eid = small_pool ? EDGE_W'($urandom_range(0, 3)) : EDGE_W'($urandom);
          va  = small_pool ? VTX_W'($urandom_range(0, 3)) : VTX_W'($urandom);
          vb  = small_pool ? VTX_W'($urandom_range(0, 3)) : VTX_W'($urandom);
          send_edge(eid, va, vb, p == n - 1, 1'b1);
        end
      end
      set_no++;
    end

    drain_results(SETTLE_CYCLES);
    if (err_count == 0) begin
      $display("edge_chain_ordering_core_test: done, clean");
    end else begin
      $display("edge_chain_ordering_core_test: done, errors");
    end
    $finish;
  end

endmodule
